[sv/hkvt_pkg.sv]
// Package: shared constants and hash mixing functions for the key-value table
`timescale 1ns / 1ps
package hkvt_pkg;
   localparam int ENTRIES_DEF       = 1024;
   localparam int BUCKETS_DEF       = 256;
   localparam int KEY_WORDS_MAX_DEF = 4;
   localparam logic [31:0] MIX_C1   = 32'hcc9e2d51;
   localparam logic [31:0] MIX_C2   = 32'h1b873593;

   localparam logic [1:0] ST_INSERTED  = 2'd0;
   localparam logic [1:0] ST_FOUND     = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam logic [1:0] CSR_KEY_WORDS   = 2'd0;
   localparam logic [1:0] CSR_VALUE_BYTES = 2'd1;
   localparam logic [1:0] CSR_ENTRY_LIMIT = 2'd2;

   // first multiply of one key word
   function automatic logic [31:0] mix_first(input logic [31:0] w);
      return w * MIX_C1;
   endfunction

   // rotate and second multiply
   function automatic logic [31:0] mix_second(input logic [31:0] d);
      return {d[16:0], d[31:17]} * MIX_C2;
   endfunction
endpackage

[sv/hkvt_hash.sv]
// Hash unit: folds the key words one multiply per cycle
`timescale 1ns / 1ps
module hkvt_hash
   import hkvt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  logic [127:0] key,
   input  logic [2:0]   words,
   output logic         done,
   output logic [31:0]  hash
);
   logic [1:0]  idx_ff, idx_in;
   logic        ph_ff, ph_in, act_ff, act_in, done_ff, done_in;
   logic [31:0] d_ff, d_in, h_ff, h_in;
   logic [31:0] w;

   assign w = key[idx_ff*32 +: 32];

   always_comb begin
      idx_in = idx_ff; ph_in = ph_ff; act_in = act_ff; done_in = 1'b0;
      d_in = d_ff; h_in = h_ff;
      if (go) begin
         idx_in = '0; ph_in = 1'b0; act_in = 1'b1; h_in = '0;
      end else if (act_ff) begin
         if (!ph_ff) begin
            d_in = mix_first(w);
            ph_in = 1'b1;
         end else begin
            if (w != '0) h_in = h_ff ^ mix_second(d_ff);
            ph_in = 1'b0;
            if ({1'b0, idx_ff} + 3'd1 >= words) begin
               act_in = 1'b0; done_in = 1'b1;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0; done_ff <= 1'b0; ph_ff <= 1'b0; idx_ff <= '0;
      end else begin
         act_ff <= act_in; done_ff <= done_in; ph_ff <= ph_in; idx_ff <= idx_in;
      end
      d_ff <= d_in;
      h_ff <= h_in;
   end

   assign done = done_ff;
   assign hash = h_ff;
endmodule

[sv/hkvt_engine.sv]
// Table engine: bucket and entry memories with insert and chain walk sequencer
`timescale 1ns / 1ps
module hkvt_engine
   import hkvt_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEF,
   parameter int BUCKETS = BUCKETS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  logic         opcode,
   input  logic [127:0] key,
   input  logic [63:0]  value,
   input  logic [31:0]  hash,
   input  logic [2:0]   words,
   input  logic [63:0]  vmask,
   input  logic [10:0]  limit,
   output logic         done,
   output logic [1:0]   status,
   output logic [63:0]  value_out
);
   localparam int EW = $clog2(ENTRIES);
   localparam int BW = $clog2(BUCKETS);

   typedef enum logic [2:0] {S_IDLE, S_HEAD, S_READ, S_CHECK} state_type;
   typedef struct packed {
      logic [127:0] key;
      logic [31:0]  hash;
      logic [EW:0]  next;
      logic [63:0]  value;
   } entry_type;

   entry_type   ent_mem [ENTRIES];
   logic [EW-1:0] head_mem [BUCKETS];
   logic [BUCKETS-1:0] bvalid_ff;

   state_type   state_ff;
   logic [EW:0] count_ff, cur_ff;
   logic [EW:0] steps_ff;
   logic        done_ff;
   logic [1:0]  status_ff;
   logic [63:0] vout_ff;
   entry_type   rd_ff;
   logic [EW-1:0] head_rd_ff;
   logic [BW-1:0] bkt;
   logic [EW:0]   cap;
   logic          keq;
   logic [127:0]  kmask;

   assign bkt = hash[BW-1:0];
   assign cap = (int'(limit) < ENTRIES) ? (EW+1)'(limit) : (EW+1)'(ENTRIES);
   always_comb begin
      for (int i = 0; i < 4; i++)
         kmask[i*32 +: 32] = (i < int'(words)) ? 32'hffffffff : 32'h0;
   end
   assign keq = ((rd_ff.key ^ key) & kmask) == '0;

   always_ff @(posedge clock) begin
      head_rd_ff <= head_mem[bkt];
      if (state_ff == S_IDLE && go && opcode == OP_INSERT && count_ff < cap) begin
         head_mem[bkt] <= count_ff[EW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= ent_mem[cur_ff[EW-1:0]];
      if (state_ff == S_HEAD && opcode == OP_INSERT)
         ent_mem[count_ff[EW-1:0]] <= '{key: key, hash: hash, value: value & vmask,
            next: bvalid_ff[bkt] ? {1'b0, head_rd_ff} : (EW+1)'(ENTRIES)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; bvalid_ff <= '0; count_ff <= '0; done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (go) begin
               if (opcode == OP_INSERT && count_ff >= cap) begin
                  done_ff <= 1'b1; status_ff <= ST_FULL; vout_ff <= '0;
               end else state_ff <= S_HEAD;
            end
            S_HEAD: begin
               if (opcode == OP_INSERT) begin
                  bvalid_ff[bkt] <= 1'b1;
                  count_ff <= count_ff + 1'b1;
                  done_ff <= 1'b1; status_ff <= ST_INSERTED; vout_ff <= '0;
                  state_ff <= S_IDLE;
               end else if (!bvalid_ff[bkt]) begin
                  done_ff <= 1'b1; status_ff <= ST_NOT_FOUND; vout_ff <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  cur_ff <= {1'b0, head_rd_ff}; steps_ff <= '0;
                  state_ff <= S_READ;
               end
            end
            S_READ: state_ff <= S_CHECK;
            S_CHECK: begin
               if (rd_ff.hash == hash && keq) begin
                  done_ff <= 1'b1; status_ff <= ST_FOUND; vout_ff <= rd_ff.value & vmask;
                  state_ff <= S_IDLE;
               end else if (rd_ff.next >= (EW+1)'(ENTRIES) || steps_ff + 1'b1 >= (EW+1)'(ENTRIES)) begin
                  done_ff <= 1'b1; status_ff <= ST_NOT_FOUND; vout_ff <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  cur_ff <= rd_ff.next; steps_ff <= steps_ff + 1'b1;
                  state_ff <= S_READ;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign status = status_ff;
   assign value_out = vout_ff;
endmodule

[sv/hashed_key_value_table.sv]
// Top level: handshake, configuration registers, hash unit and table engine
`timescale 1ns / 1ps
// One item at a time: start is taken while busy is low, and busy falls at the
// edge that ends the result cycle. The hash does a multiply step and then a
// rotate and multiply step per key word. An insert then writes the bucket head
// and the entry; an insert into a full table answers from the idle state. A
// lookup reads the bucket head, then visits each chain entry with a memory read
// and a compare. The sustained rate therefore depends on how long the chains
// are. Results appear for one cycle on rsp_valid and cannot be stalled.
module hashed_key_value_table
   import hkvt_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEF,
   parameter int BUCKETS = BUCKETS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic         req_opcode,
   input  logic [63:0]  req_key_low,
   input  logic [63:0]  req_key_high,
   input  logic [63:0]  req_value_in,
   output logic         rsp_valid,
   output logic [1:0]   rsp_status,
   output logic [63:0]  rsp_value_out,
   output logic [31:0]  rsp_key_hash,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [10:0]  csr_data
);
   logic [2:0]   kw_ff;
   logic [3:0]   vb_ff;
   logic [10:0]  lim_ff;
   logic         busy_ff, op_ff;
   logic [127:0] key_ff;
   logic [63:0]  val_ff, vmask;
   logic [2:0]   words;
   logic         hdone, edone;
   logic [31:0]  hash;
   logic [1:0]   st;
   logic [63:0]  vo;
   logic         accept;

   assign accept = start && !busy_ff;
   assign words = (kw_ff == 3'd0) ? 3'd1 :
                  (kw_ff > 3'(KEY_WORDS_MAX_DEF)) ? 3'(KEY_WORDS_MAX_DEF) : kw_ff;
   always_comb begin
      for (int i = 0; i < 8; i++)
         vmask[i*8 +: 8] = (i < int'(vb_ff) || i == 0) ? 8'hff : 8'h00;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kw_ff <= 3'd1; vb_ff <= 4'd8; lim_ff <= 11'd1024; busy_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_KEY_WORDS:   kw_ff <= csr_data[2:0];
               CSR_VALUE_BYTES: vb_ff <= csr_data[3:0];
               CSR_ENTRY_LIMIT: lim_ff <= csr_data;
               default: ;
            endcase
         end
         if (accept) busy_ff <= 1'b1;
         else if (edone) busy_ff <= 1'b0;
      end
      if (accept) begin
         op_ff <= req_opcode; key_ff <= {req_key_high, req_key_low}; val_ff <= req_value_in;
      end
   end

   hkvt_hash u_hash (
      .clock(clock), .reset(reset), .go(accept), .key(key_ff),
      .words(words), .done(hdone), .hash(hash)
   );

   hkvt_engine #(.ENTRIES(ENTRIES), .BUCKETS(BUCKETS)) u_engine (
      .clock(clock), .reset(reset), .go(hdone), .opcode(op_ff), .key(key_ff),
      .value(val_ff), .hash(hash), .words(words), .vmask(vmask), .limit(lim_ff),
      .done(edone), .status(st), .value_out(vo)
   );

   assign busy = busy_ff;
   assign rsp_valid = edone;
   assign rsp_status = st;
   assign rsp_value_out = vo;
   assign rsp_key_hash = hash;
endmodule

[sv/hkvt_checker.sv]
// Port checker for the key-value table, bound to the top level
`timescale 1ns / 1ps
module hkvt_props
   import hkvt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status,
   input logic [63:0] rsp_value_out
);
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("word without an item in flight");
   a_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted item not held");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_FOUND |-> rsp_value_out == '0)
      else $error("value on a non-found word");
   a_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy held after word");
endmodule

bind hashed_key_value_table hkvt_props u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_value_out(rsp_value_out)
);
